// ----- hw/rtl/slcg_pkg.sv -----
// ----------------------------------------------------------------------------
// slcg_pkg
// shared types and constants of the shuffled congruential generator
// ----------------------------------------------------------------------------
`default_nettype none

package slcg_pkg;

  // value and operand widths
  localparam int VAL_W  = 20;
  localparam int SEED_W = 32;
  localparam int NUM_W  = 32;

  // congruential generator x' = (GEN_MUL * x + GEN_ADD) mod GEN_MOD
  localparam logic [VAL_W-1:0] GEN_MOD = 20'd714025;
  localparam logic [VAL_W-1:0] GEN_MUL = 20'd1366;
  localparam logic [VAL_W-1:0] GEN_ADD = 20'd150889;

  // reciprocal of GEN_MOD, rounded down, scaled by 2**RECIP_SHIFT
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 40;
  localparam int QUO_W       = NUM_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] GEN_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(GEN_MOD));

  typedef struct packed {
    logic                     reseed;
    logic signed [SEED_W-1:0] seed;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] random_numerator;
    logic [VAL_W-1:0] generator_state;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the seed of the accepted word
    logic lcg_start;   // launch one generator step
    logic lcg_raw;     // step reduces the seed magnitude instead
    logic slot_start;  // launch the slot computation
    logic fill_we;     // write the step result at the fill address
    logic held_load;   // last seeding step sets the held value
    logic ram_re;      // read the table at the chosen slot
    logic commit;      // finish the draw
  } slcg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic lcg_done;
    logic slot_done;
  } slcg_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/slcg_ram.sv -----
// ----------------------------------------------------------------------------
// slcg_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module slcg_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 97
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/slcg_modm.sv -----
// ----------------------------------------------------------------------------
// slcg_modm
// three stage quotient and remainder by the generator modulus
// ----------------------------------------------------------------------------
`default_nettype none

module slcg_modm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [slcg_pkg::NUM_W-1:0] num,
  output logic                      out_valid,
  output logic [slcg_pkg::QUO_W-1:0] quo,
  output logic [slcg_pkg::VAL_W-1:0] rem
);

  import slcg_pkg::*;

  localparam int PROD_W = NUM_W + RECIP_W;
  localparam int QM_W   = QUO_W + VAL_W;

  logic             s1_valid_r, s2_valid_r, s3_valid_r;
  logic [NUM_W-1:0] num1_r, num2_r;
  logic [QUO_W-1:0] q0_r, q3_r;
  logic [VAL_W:0]   r0_r;

  logic [PROD_W-1:0] prod;
  logic [QM_W-1:0]   qm;
  logic [QM_W-1:0]   diff;
  logic [VAL_W:0]    r0_sub;
  logic              r0_ge;

  // estimate is exact or one low
  assign prod = PROD_W'(num1_r) * PROD_W'(GEN_RECIP);
  assign qm   = QM_W'(q0_r) * QM_W'(GEN_MOD);
  assign diff = QM_W'(num2_r) - qm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
    num1_r <= num;
    num2_r <= num1_r;
    q0_r   <= prod[PROD_W-1:RECIP_SHIFT];
    q3_r   <= q0_r;
    r0_r   <= diff[VAL_W:0];
  end

  // one correction step
  assign r0_ge  = (r0_r >= {1'b0, GEN_MOD});
  assign r0_sub = r0_r - {1'b0, GEN_MOD};

  assign out_valid = s3_valid_r;
  assign quo       = q3_r + QUO_W'(r0_ge);
  assign rem       = r0_ge ? r0_sub[VAL_W-1:0] : r0_r[VAL_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/slcg_dpath.sv -----
// ----------------------------------------------------------------------------
// slcg_dpath
// generator state, held value, slot choice and shuffle table
// ----------------------------------------------------------------------------
`default_nettype none

module slcg_dpath #(
  parameter int TABLE_DEPTH = 97
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  slcg_pkg::slcg_cmd_t            cmd,
  input  slcg_pkg::in_word_t             in_word,
  input  logic [$clog2(TABLE_DEPTH)-1:0] fill_addr,
  output slcg_pkg::slcg_sts_t            sts,
  output slcg_pkg::out_word_t            out_word
);

  import slcg_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [SEED_W-1:0] seed_mag_r;
  logic [VAL_W-1:0]  x_r;
  logic [VAL_W-1:0]  held_r;
  logic [ADDR_W-1:0] slot_r;
  out_word_t         out_word_r;

  logic [SEED_W:0]   seed_diff;
  logic [SEED_W:0]   seed_abs;
  logic [NUM_W-1:0]  step_num;
  logic [NUM_W-1:0]  lcg_num;
  logic [NUM_W-1:0]  slot_num;

  logic              lcg_valid, slot_valid;
  logic [QUO_W-1:0]  lcg_quo, slot_quo;
  logic [VAL_W-1:0]  lcg_rem, slot_rem;
  logic [ADDR_W-1:0] slot_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;

  // start value: magnitude of (add - seed), reduced below
  assign seed_diff = (SEED_W+1)'(GEN_ADD) - {in_word.seed[SEED_W-1], in_word.seed};
  assign seed_abs  = seed_diff[SEED_W] ? (~seed_diff + 1'b1) : seed_diff;

  assign step_num = NUM_W'(x_r) * NUM_W'(GEN_MUL) + NUM_W'(GEN_ADD);
  assign lcg_num  = cmd.lcg_raw ? NUM_W'(seed_mag_r) : step_num;
  assign slot_num = NUM_W'(held_r) * NUM_W'(TABLE_DEPTH);

  slcg_modm u_lcg_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.lcg_start),
    .num       (lcg_num),
    .out_valid (lcg_valid),
    .quo       (lcg_quo),
    .rem       (lcg_rem)
  );

  slcg_modm u_slot_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.slot_start),
    .num       (slot_num),
    .out_valid (slot_valid),
    .quo       (slot_quo),
    .rem       (slot_rem)
  );

  // slot index, held at the last entry if out of range
  always_comb begin
    if (slot_quo >= QUO_W'(TABLE_DEPTH)) begin
      slot_nxt = ADDR_W'(TABLE_DEPTH - 1);
    end else begin
      slot_nxt = slot_quo[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seed_mag_r <= seed_abs[SEED_W-1:0];
    end
    if (lcg_valid) begin
      x_r <= lcg_rem;
    end
    if (slot_valid) begin
      slot_r <= slot_nxt;
    end
    if (cmd.held_load) begin
      held_r <= lcg_rem;
    end else if (cmd.commit) begin
      held_r <= ram_rdata;
    end
    if (cmd.commit) begin
      out_word_r.random_numerator <= ram_rdata;
      out_word_r.generator_state  <= x_r;
    end
  end

  assign ram_we    = cmd.fill_we | cmd.commit;
  assign ram_waddr = cmd.commit ? slot_r : fill_addr;
  assign ram_wdata = cmd.commit ? x_r : lcg_rem;

  slcg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign sts.lcg_done  = lcg_valid;
  assign sts.slot_done = slot_valid;
  assign out_word      = out_word_r;

endmodule

`default_nettype wire

// ----- hw/rtl/slcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// slcg_ctrl
// sequencer for seeding and draws
// ----------------------------------------------------------------------------
`default_nettype none

module slcg_ctrl #(
  parameter int TABLE_DEPTH = 97
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_reseed,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  slcg_pkg::slcg_sts_t            sts,
  output slcg_pkg::slcg_cmd_t            cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0] fill_addr
);

  import slcg_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_GO,
    S_START_WAIT,
    S_STEP_GO,
    S_STEP_WAIT,
    S_DRAW_GO,
    S_DRAW_WAIT,
    S_READ,
    S_COMMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             seeded_r, seeded_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    seeded_nxt    = seeded_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_reseed || !seeded_r) ? S_SEED_GO : S_DRAW_GO;
        end
      end
      S_SEED_GO: begin
        cmd.lcg_start = 1'b1;
        cmd.lcg_raw   = 1'b1;
        k_nxt         = '0;
        state_nxt     = S_START_WAIT;
      end
      S_START_WAIT: begin
        if (sts.lcg_done) begin
          state_nxt = S_STEP_GO;
        end
      end
      S_STEP_GO: begin
        cmd.lcg_start = 1'b1;
        state_nxt     = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (sts.lcg_done) begin
          if (k_r < CNT_W'(TABLE_DEPTH)) begin
            cmd.fill_we = 1'b1;
            k_nxt       = k_r + 1'b1;
            state_nxt   = S_STEP_GO;
          end else begin
            cmd.held_load = 1'b1;
            seeded_nxt    = 1'b1;
            state_nxt     = S_DRAW_GO;
          end
        end
      end
      S_DRAW_GO: begin
        cmd.slot_start = 1'b1;
        cmd.lcg_start  = 1'b1;
        state_nxt      = S_DRAW_WAIT;
      end
      S_DRAW_WAIT: begin
        if (sts.slot_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.ram_re = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fill_addr = k_r[ADDR_W-1:0];

`ifndef SYNTHESIS
  // a finished draw never overwrites a word still waiting downstream
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("draw committed over a pending word");

  // a draw only starts from a seeded table
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW_GO) |-> seeded_r)
    else $error("draw started on an unseeded table");

  // the generator unit only answers while a wait state expects it
  assert property (@(posedge clk) disable iff (!rst_n)
    sts.lcg_done |-> (state_r == S_START_WAIT || state_r == S_STEP_WAIT ||
                      state_r == S_DRAW_WAIT))
    else $error("unexpected generator result");

  // an accepted word always leaves idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted word was dropped");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/shuffled_lcg_random_generator.sv -----
// ----------------------------------------------------------------------------
// shuffled_lcg_random_generator
// congruential generator with a shuffle table in front of its output
// ----------------------------------------------------------------------------
// draw: slot and generator steps run through the 3-stage modulus units, then
//   a table read and commit; a new word is taken only after the commit
// seeding (reseed set, or first word after reset): one generator pass reduces
//   the seed, one fills each table entry and one more sets the held value
// reset: synchronous active low, clears the sequencer and the seeded flag;
//   the table is filled by seeding and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module shuffled_lcg_random_generator #(
  parameter int TABLE_DEPTH = 97
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slcg_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output slcg_pkg::out_word_t out_word
);

  import slcg_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  // command and status between sequencer and datapath
  slcg_cmd_t         cmd;
  slcg_sts_t         sts;
  // table index used while seeding fills entries in order
  logic [ADDR_W-1:0] fill_addr;

  // sequencer: accepts a word, seeds the table when needed, then runs
  // one draw and parks the result in the output register
  slcg_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_reseed (in_word.reseed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .fill_addr (fill_addr)
  );

  // datapath: generator state, held value, slot unit and shuffle table;
  // a draw returns the slot's old content and stores the new generator value
  slcg_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .fill_addr (fill_addr),
    .sts       (sts),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
